### rtl/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg
// shared constants, codes, request/response types and helpers for the
// sorted slot list engine
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int VAL_W      = 32;
  localparam int CMD_W      = 2;
  localparam int ST_W       = 2;
  localparam int IO_SLOT_W  = 5;
  // wide enough for both the port slot field and an internal slot index
  localparam int WIDE_W     = (SLOT_W > IO_SLOT_W) ? SLOT_W : IO_SLOT_W;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_SLOT  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // control from the sequencer to the slot allocator
  typedef struct packed {
    logic  scan_start;
    logic  set_en;
    logic  clr_en;
    slot_t idx;
  } alloc_req_t;

  // status from the slot allocator
  typedef struct packed {
    logic  scan_done;
    logic  scan_found;
    slot_t free_slot;
    logic  query_in_use;
  } alloc_rsp_t;

  // low bits of a slot index as carried on the result port
  function automatic logic [IO_SLOT_W-1:0] to_io_slot(input slot_t s);
    logic [WIDE_W-1:0] t;
    t = WIDE_W'(s);
    return t[IO_SLOT_W-1:0];
  endfunction

endpackage

### rtl/ssl_if.sv
// ----------------------------------------------------------------------------
// ssl_in_if / ssl_out_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface ssl_in_if;
  import ssl_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] key_value;
  logic [IO_SLOT_W-1:0]    slot_number;

  modport source (output valid, command, key_value, slot_number, input ready);
  modport sink   (input valid, command, key_value, slot_number, output ready);
endinterface

interface ssl_out_if;
  import ssl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      status;
  logic [IO_SLOT_W-1:0] result_slot;

  modport source (output valid, status, result_slot, input ready);
  modport sink   (input valid, status, result_slot, output ready);
endinterface

### rtl/ssl_ram.sv
// ----------------------------------------------------------------------------
// ssl_ram
// generic one-write one-read synchronous ram, registered read data
// ----------------------------------------------------------------------------
module ssl_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ssl_alloc.sv
// ----------------------------------------------------------------------------
// ssl_alloc
// slot in-use flags and a one-slot-per-cycle scan for the lowest free slot
// ----------------------------------------------------------------------------
module ssl_alloc (
  input  logic               clk,
  input  logic               rst_n,
  input  ssl_pkg::alloc_req_t req,
  output ssl_pkg::alloc_rsp_t rsp
);
  import ssl_pkg::*;

  localparam slot_t LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  logic [SLOT_COUNT-1:0] in_use_r;
  slot_t                 scan_idx_r;
  logic                  scanning_r;
  logic                  done_r;
  logic                  found_r;
  slot_t                 free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r   <= SLOT_COUNT'(1);  // anchor always in use
      scanning_r <= 1'b0;
      done_r     <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      if (req.set_en) begin
        in_use_r[req.idx] <= 1'b1;
      end
      if (req.clr_en) begin
        in_use_r[req.idx] <= 1'b0;
      end
      if (req.scan_start) begin
        scan_idx_r <= SLOT_W'(1);
        scanning_r <= 1'b1;
        done_r     <= 1'b0;
        found_r    <= 1'b0;
      end else if (scanning_r) begin
        if (!in_use_r[scan_idx_r]) begin
          free_r     <= scan_idx_r;
          found_r    <= 1'b1;
          done_r     <= 1'b1;
          scanning_r <= 1'b0;
        end else if (scan_idx_r == LAST_SLOT) begin
          done_r     <= 1'b1;
          scanning_r <= 1'b0;
        end else begin
          scan_idx_r <= scan_idx_r + SLOT_W'(1);
        end
      end
    end
  end

  assign rsp.scan_done    = done_r;
  assign rsp.scan_found   = found_r;
  assign rsp.free_slot    = free_r;
  assign rsp.query_in_use = in_use_r[req.idx];

endmodule

### rtl/ssl_ctrl.sv
// ----------------------------------------------------------------------------
// ssl_ctrl
// command sequencer: list walk, link update and result register
// ----------------------------------------------------------------------------
module ssl_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  ssl_in_if.sink                   in_if,
  ssl_out_if.source                out_if,
  output ssl_pkg::alloc_req_t      alloc_req,
  input  ssl_pkg::alloc_rsp_t      alloc_rsp,
  output ssl_pkg::slot_t           rd_addr,
  input  logic [ssl_pkg::VAL_W-1:0] val_rdata,
  input  ssl_pkg::slot_t           nxt_rdata,
  input  ssl_pkg::slot_t           prv_rdata,
  output logic                     val_we,
  output ssl_pkg::slot_t           val_waddr,
  output logic [ssl_pkg::VAL_W-1:0] val_wdata,
  output logic                     nxt_we,
  output ssl_pkg::slot_t           nxt_waddr,
  output ssl_pkg::slot_t           nxt_wdata,
  output logic                     prv_we,
  output ssl_pkg::slot_t           prv_waddr,
  output ssl_pkg::slot_t           prv_wdata
);
  import ssl_pkg::*;

  localparam slot_t LAST_STEP = SLOT_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_INS_WAIT,
    S_LINK_A,
    S_LINK_B,
    S_DEL_CHK,
    S_DEL_WR,
    S_FINISH
  } state_t;

  state_t                  state_r;
  logic signed [VAL_W-1:0] key_r;
  logic                    is_ins_r;
  slot_t                   cur_r;
  slot_t                   pred_r;
  slot_t                   succ_r;
  slot_t                   step_r;
  slot_t                   slot_idx_r;
  logic                    slot_ok_r;
  slot_t                   anchor_next_r;
  status_t                 res_status_r;
  slot_t                   res_slot_r;
  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [IO_SLOT_W-1:0]    out_slot_r;

  logic              val_lt;
  logic              val_eq;
  logic              walk_end;
  logic              del_ok;
  logic [WIDE_W-1:0] slot_ext;

  assign val_lt   = $signed(val_rdata) < key_r;
  assign val_eq   = $signed(val_rdata) == key_r;
  assign walk_end = (nxt_rdata == '0) || (step_r == LAST_STEP);
  assign del_ok   = slot_ok_r && (slot_idx_r != '0) && alloc_rsp.query_in_use;
  assign slot_ext = WIDE_W'(in_if.slot_number);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      anchor_next_r <= '0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      // the anchor's forward link is mirrored in a register beside the ram
      if (nxt_we && (nxt_waddr == '0)) begin
        anchor_next_r <= nxt_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            key_r  <= in_if.key_value;
            cur_r  <= anchor_next_r;
            pred_r <= '0;
            succ_r <= '0;
            step_r <= SLOT_W'(1);
            case (cmd_t'(in_if.command))
              CMD_INSERT: begin
                is_ins_r <= 1'b1;
                state_r  <= (anchor_next_r == '0) ? S_INS_WAIT : S_WALK;
              end
              CMD_FIND: begin
                is_ins_r <= 1'b0;
                if (anchor_next_r == '0) begin
                  res_status_r <= ST_NOT_FOUND;
                  res_slot_r   <= '0;
                  state_r      <= S_FINISH;
                end else begin
                  state_r <= S_WALK;
                end
              end
              CMD_DELETE: begin
                slot_idx_r <= slot_ext[SLOT_W-1:0];
                slot_ok_r  <= slot_ext <= WIDE_W'(SLOT_COUNT - 1);
                state_r    <= S_DEL_CHK;
              end
              default: begin
                res_status_r <= ST_OK;
                res_slot_r   <= '0;
                state_r      <= S_FINISH;
              end
            endcase
          end
        end
        S_WALK: begin
          if (is_ins_r) begin
            if (!val_lt) begin
              succ_r  <= cur_r;
              state_r <= S_INS_WAIT;
            end else begin
              pred_r <= cur_r;
              if (walk_end) begin
                succ_r  <= '0;
                state_r <= S_INS_WAIT;
              end else begin
                cur_r  <= nxt_rdata;
                step_r <= step_r + SLOT_W'(1);
              end
            end
          end else begin
            if (val_eq) begin
              res_status_r <= ST_OK;
              res_slot_r   <= cur_r;
              state_r      <= S_FINISH;
            end else if (!val_lt || walk_end) begin
              res_status_r <= ST_NOT_FOUND;
              res_slot_r   <= '0;
              state_r      <= S_FINISH;
            end else begin
              cur_r  <= nxt_rdata;
              step_r <= step_r + SLOT_W'(1);
            end
          end
        end
        S_INS_WAIT: begin
          if (alloc_rsp.scan_done) begin
            if (alloc_rsp.scan_found) begin
              state_r <= S_LINK_A;
            end else begin
              res_status_r <= ST_FULL;
              res_slot_r   <= '0;
              state_r      <= S_FINISH;
            end
          end
        end
        S_LINK_A: begin
          state_r <= S_LINK_B;
        end
        S_LINK_B: begin
          res_status_r <= ST_OK;
          res_slot_r   <= alloc_rsp.free_slot;
          state_r      <= S_FINISH;
        end
        S_DEL_CHK: begin
          if (del_ok) begin
            state_r <= S_DEL_WR;
          end else begin
            res_status_r <= ST_BAD_SLOT;
            res_slot_r   <= '0;
            state_r      <= S_FINISH;
          end
        end
        S_DEL_WR: begin
          res_status_r <= ST_OK;
          res_slot_r   <= '0;
          state_r      <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= to_io_slot(res_slot_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // read address: first list entry, next link during the walk, else the delete slot
  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = anchor_next_r;
      S_WALK:  rd_addr = nxt_rdata;
      default: rd_addr = slot_idx_r;
    endcase
  end

  always_comb begin
    alloc_req.scan_start = (state_r == S_IDLE) && in_if.valid
                           && (cmd_t'(in_if.command) == CMD_INSERT);
    alloc_req.set_en     = (state_r == S_LINK_A);
    alloc_req.clr_en     = (state_r == S_DEL_CHK) && del_ok;
    alloc_req.idx        = (state_r == S_LINK_A) ? alloc_rsp.free_slot : slot_idx_r;
  end

  always_comb begin
    val_we    = (state_r == S_LINK_A);
    val_waddr = alloc_rsp.free_slot;
    val_wdata = key_r;
    nxt_we    = 1'b0;
    nxt_waddr = alloc_rsp.free_slot;
    nxt_wdata = succ_r;
    prv_we    = 1'b0;
    prv_waddr = alloc_rsp.free_slot;
    prv_wdata = pred_r;
    case (state_r)
      S_LINK_A: begin
        nxt_we = 1'b1;
        prv_we = 1'b1;
      end
      S_LINK_B: begin
        nxt_we    = 1'b1;
        nxt_waddr = pred_r;
        nxt_wdata = alloc_rsp.free_slot;
        prv_we    = 1'b1;
        prv_waddr = succ_r;
        prv_wdata = alloc_rsp.free_slot;
      end
      S_DEL_WR: begin
        nxt_we    = 1'b1;
        nxt_waddr = prv_rdata;
        nxt_wdata = nxt_rdata;
        prv_we    = 1'b1;
        prv_waddr = nxt_rdata;
        prv_wdata = prv_rdata;
      end
      default: begin
        nxt_we = 1'b0;
        prv_we = 1'b0;
      end
    endcase
  end

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.status      = out_status_r;
  assign out_if.result_slot = out_slot_r;

endmodule

### rtl/sorted_slot_list_engine_top.sv
// ----------------------------------------------------------------------------
// sorted_slot_list_engine_top
// insert: list walk beside the free scan, then link a, link b and finish
// find: list walk, then finish; delete: check, write, finish; unused command: finish
// one command at a time; the rate is set by the link walk (one ram read
// per entry), the one-slot-per-cycle free scan beside it and result stalls
// reset: synchronous, clears the list to the lone anchor, only it in use
// ----------------------------------------------------------------------------
module sorted_slot_list_engine_top (
  input logic       clk,
  input logic       rst_n,
  ssl_in_if.sink    in_if,
  ssl_out_if.source out_if
);
  import ssl_pkg::*;

  // allocator handshake between sequencer and in-use flags
  alloc_req_t        alloc_req;
  alloc_rsp_t        alloc_rsp;

  // shared read address for all three rams, registered data back
  slot_t             rd_addr;
  logic [VAL_W-1:0]  val_rdata;
  slot_t             nxt_rdata;
  slot_t             prv_rdata;

  // write ports
  logic              val_we;
  slot_t             val_waddr;
  logic [VAL_W-1:0]  val_wdata;
  logic              nxt_we;
  slot_t             nxt_waddr;
  slot_t             nxt_wdata;
  logic              prv_we;
  slot_t             prv_waddr;
  slot_t             prv_wdata;

  // sequencer: walks the list, links and unlinks, holds the result register
  ssl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .alloc_req (alloc_req),
    .alloc_rsp (alloc_rsp),
    .rd_addr   (rd_addr),
    .val_rdata (val_rdata),
    .nxt_rdata (nxt_rdata),
    .prv_rdata (prv_rdata),
    .val_we    (val_we),
    .val_waddr (val_waddr),
    .val_wdata (val_wdata),
    .nxt_we    (nxt_we),
    .nxt_waddr (nxt_waddr),
    .nxt_wdata (nxt_wdata),
    .prv_we    (prv_we),
    .prv_waddr (prv_waddr),
    .prv_wdata (prv_wdata)
  );

  // in-use flags and lowest-free-slot scan
  ssl_alloc u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alloc_req),
    .rsp   (alloc_rsp)
  );

  // slot values, written when a slot is claimed
  ssl_ram #(.DEPTH(SLOT_COUNT), .WIDTH(VAL_W)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  // forward links; the anchor's forward link is mirrored in a register
  ssl_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SLOT_W)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (rd_addr),
    .rdata (nxt_rdata)
  );

  // backward links, used only to unlink a deleted slot
  ssl_ram #(.DEPTH(SLOT_COUNT), .WIDTH(SLOT_W)) u_prv_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (rd_addr),
    .rdata (prv_rdata)
  );

`ifndef NO_ASSERTIONS
  // the anchor slot is never freed
  a_anchor_kept: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_req.clr_en |-> alloc_req.idx != '0)
    else $error("anchor slot freed");

  // a value is only written into the slot being claimed in that cycle
  a_value_claim: assert property (@(posedge clk) disable iff (!rst_n)
    val_we |-> (alloc_req.set_en && alloc_req.idx == val_waddr))
    else $error("value written outside slot claim");

  // the free scan never hands out the anchor
  a_free_not_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_rsp.scan_found |-> alloc_rsp.free_slot != '0)
    else $error("free scan returned anchor");

  // a claimed slot is still marked free in the cycle it is claimed
  a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_req.set_en |-> !alloc_rsp.query_in_use)
    else $error("claimed slot already in use");
`endif

endmodule
